[rtl/tcpw_pkg.sv]
package tcpw_pkg;

	localparam int SESSION_COUNT = 1024;
	localparam int WINDOW_WIDTH  = 16;
	localparam int ADDR_W        = $clog2(SESSION_COUNT);

	localparam logic [2:0] ACT_TX_LOOKUP   = 3'd0;
	localparam logic [2:0] ACT_APP_READ    = 3'd1;
	localparam logic [2:0] ACT_APP_WRITE   = 3'd2;
	localparam logic [2:0] ACT_ENG_READ    = 3'd3;
	localparam logic [2:0] ACT_ENG_WRITE   = 3'd4;
	localparam logic [2:0] ACT_ENG_INIT    = 3'd5;

	localparam logic [1:0] KIND_TX_LOOKUP  = 2'd0;
	localparam logic [1:0] KIND_APP_READ   = 2'd1;
	localparam logic [1:0] KIND_ENG_READ   = 2'd2;

	typedef struct packed {
		logic [2:0]  action;
		logic [9:0]  session;
		logic [31:0] seq_in;
		logic [15:0] pointer_in;
		logic [3:0]  scale_in;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [9:0]  session_out;
		logic [31:0] seq_out;
		logic [15:0] pointer_out;
		logic [3:0]  scale_out;
		logic [15:0] window_out;
	} rsp_t;

	typedef struct packed {
		logic [31:0]             seq;
		logic [WINDOW_WIDTH-1:0] ptr;
		logic [3:0]              scale;
	} entry_t;

	typedef struct packed {
		logic              rd_en;
		logic              seq_we;
		logic              ptr_we;
		logic              scale_we;
		logic [ADDR_W-1:0] addr;
	} store_ctl_t;

endpackage

[rtl/tcp_rx_window_state_table_unit.sv]
// channel | valid     | ready     | payload
// request | req_valid | req_ready | req (tcpw_pkg::req_t)
// result  | rsp_valid | rsp_ready | rsp (tcpw_pkg::rsp_t)
//
// One request per cycle. A read request is answered through the session
// table's registered read port and then the result register. Writes update
// the table at the edge that takes them, so a read taken in the next cycle
// already sees them. Reset clears only the valid flags; table contents stay
// undefined until written. A stalled result holds the read stage, and one
// waiting read then stalls the request side.
module tcp_rx_window_state_table_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  tcpw_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output tcpw_pkg::rsp_t rsp
);
	import tcpw_pkg::*;

	localparam int WIN_W = WINDOW_WIDTH;

	logic       accept;
	logic       sess_ok;
	logic       has_result;
	store_ctl_t ctl;
	entry_t     wr_data;
	entry_t     rd_data;

	logic       valid_s1;
	logic [2:0] action_s1;
	logic [9:0] session_s1;
	logic       ok_s1;
	logic       advance_s1;

	entry_t     ent;
	logic [WIN_W-1:0] win_diff;
	logic [WIN_W-1:0] win_adv;
	rsp_t       rsp_d;
	rsp_t       rsp_q;
	logic       rsp_valid_q;

	assign advance_s1 = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready  = !valid_s1 || advance_s1;
	assign accept     = req_valid && req_ready;
	assign sess_ok    = {22'd0, req.session} < 32'(SESSION_COUNT);

	// decode the request into table port controls
	always_comb begin
		ctl          = '0;
		ctl.addr     = ADDR_W'(req.session);
		has_result   = 1'b0;
		wr_data.seq   = req.seq_in;
		wr_data.ptr   = WIN_W'(req.pointer_in);
		wr_data.scale = req.scale_in;
		unique case (req.action)
			ACT_TX_LOOKUP, ACT_APP_READ, ACT_ENG_READ: begin
				has_result = 1'b1;
				ctl.rd_en  = accept;
			end
			ACT_APP_WRITE: begin
				ctl.ptr_we = accept && sess_ok;
			end
			ACT_ENG_WRITE: begin
				ctl.seq_we = accept && sess_ok;
			end
			ACT_ENG_INIT: begin
				ctl.seq_we   = accept && sess_ok;
				ctl.ptr_we   = accept && sess_ok;
				ctl.scale_we = accept && sess_ok;
				wr_data.ptr  = WIN_W'(req.seq_in);
			end
			default: begin
			end
		endcase
	end

	tcpw_entry_store u_store (
		.clk     (clk),
		.ctl     (ctl),
		.wr_data (wr_data),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= has_result;
		end else if (advance_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1  <= req.action;
			session_s1 <= req.session;
			ok_s1      <= sess_ok;
		end
	end

	// out-of-range sessions read as an all-zero entry
	always_comb begin
		ent       = ok_s1 ? rd_data : '0;
		win_diff  = ent.ptr - ent.seq[WIN_W-1:0] - WIN_W'(1);
		win_adv   = ok_s1 ? (win_diff >> ent.scale) : '0;
		rsp_d     = '0;
		case (action_s1)
			ACT_TX_LOOKUP: begin
				rsp_d.kind       = KIND_TX_LOOKUP;
				rsp_d.seq_out    = ent.seq;
				rsp_d.scale_out  = ent.scale;
				rsp_d.window_out = 16'(win_adv);
			end
			ACT_APP_READ: begin
				rsp_d.kind        = KIND_APP_READ;
				rsp_d.session_out = session_s1;
				rsp_d.pointer_out = 16'(ent.ptr);
			end
			ACT_ENG_READ: begin
				rsp_d.kind        = KIND_ENG_READ;
				rsp_d.seq_out     = ent.seq;
				rsp_d.pointer_out = 16'(ent.ptr);
				rsp_d.scale_out   = ent.scale;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance_s1) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_s1) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req.action == ACT_APP_WRITE || req.action == ACT_ENG_WRITE ||
			req.action == ACT_ENG_INIT)) |=> !valid_s1)
		else $error("write request produced a pending result");

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> (valid_s1 && rsp_valid_q && !rsp_ready))
		else $error("request side stalled with room in the pipeline");

	a_app_read_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.kind == KIND_APP_READ) |->
			(rsp.seq_out == 32'd0 && rsp.scale_out == 4'd0 && rsp.window_out == 16'd0))
		else $error("app read response carries stray fields");

	a_kind_from_action: assert property (@(posedge clk) disable iff (!arst_n)
		advance_s1 |=> (rsp.kind == KIND_TX_LOOKUP) == ($past(action_s1) == ACT_TX_LOOKUP))
		else $error("response kind does not match request action");
`endif

endmodule

[rtl/tcpw_entry_store.sv]
module tcpw_entry_store (
	input  logic                clk,
	input  tcpw_pkg::store_ctl_t ctl,
	input  tcpw_pkg::entry_t    wr_data,
	output tcpw_pkg::entry_t    rd_data
);
	import tcpw_pkg::*;

	// one array per field so partial writes need no read-modify-write
	logic [31:0]             seq_mem   [SESSION_COUNT];
	logic [WINDOW_WIDTH-1:0] ptr_mem   [SESSION_COUNT];
	logic [3:0]              scale_mem [SESSION_COUNT];

	always_ff @(posedge clk) begin
		if (ctl.seq_we) begin
			seq_mem[ctl.addr] <= wr_data.seq;
		end
		if (ctl.ptr_we) begin
			ptr_mem[ctl.addr] <= wr_data.ptr;
		end
		if (ctl.scale_we) begin
			scale_mem[ctl.addr] <= wr_data.scale;
		end
	end

	// read data holds while the read enable is low
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data.seq   <= seq_mem[ctl.addr];
			rd_data.ptr   <= ptr_mem[ctl.addr];
			rd_data.scale <= scale_mem[ctl.addr];
		end
	end

endmodule
